// ----- rtl/wcsg_pkg.sv -----
// shared types, constants and helpers for the wave channel sound generator
package wcsg_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_IDX_W = $clog2(WAVE_BYTES);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [15:0] ADDR_NR30 = 16'hFF1A;
    localparam logic [15:0] ADDR_NR31 = 16'hFF1B;
    localparam logic [15:0] ADDR_NR32 = 16'hFF1C;
    localparam logic [15:0] ADDR_NR33 = 16'hFF1D;
    localparam logic [15:0] ADDR_NR34 = 16'hFF1E;
    localparam logic [15:0] WAVE_BASE = 16'hFF30;

    localparam logic [7:0] MASK_NR30 = 8'h7F;
    localparam logic [7:0] MASK_NR32 = 8'h9F;
    localparam logic [7:0] MASK_NR34 = 8'hBF;
    localparam logic [7:0] READ_OPEN = 8'hFF;

    localparam logic [11:0] PERIOD_SPAN  = 12'd2048;
    localparam logic [12:0] TRIG_DIVIDER = 13'd6;
    localparam logic [12:0] CORRUPT_DIV  = 13'd2;
    localparam logic [1:0]  FETCH_WINDOW = 2'd2;

    // volume codes from bits 6..5 of nr32
    localparam logic [1:0] VOL_MUTE    = 2'd0;
    localparam logic [1:0] VOL_FULL    = 2'd1;
    localparam logic [1:0] VOL_HALF    = 2'd2;
    localparam logic [1:0] VOL_QUARTER = 2'd3;

    localparam logic [0:0] CFG_COLOUR = 1'b0;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        length_expired;
    } t_item;

    typedef struct packed {
        logic       bad_address;
        logic [7:0] read_data;
        logic [3:0] sample;
    } t_result;

    function automatic logic [3:0] wcsg_scale(input logic [1:0] code,
                                              input logic [3:0] nib);
        logic [3:0] lvl;
        case (code)
            VOL_MUTE:    lvl = 4'd0;
            VOL_FULL:    lvl = nib;
            VOL_HALF:    lvl = nib >> 1;
            VOL_QUARTER: lvl = nib >> 2;
            default:     lvl = 4'd0;
        endcase
        return lvl;
    endfunction

    // power-up pattern 00 ff 00 ff ...
    function automatic logic [7:0] wcsg_wave_init(input logic [WAVE_IDX_W-1:0] idx);
        return idx[0] ? 8'hFF : 8'h00;
    endfunction

endpackage

// ----- rtl/wcsg_chan.sv -----
// channel state and item processing
module wcsg_chan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  wcsg_pkg::t_item  i_item,
    input  logic             i_colour,
    output wcsg_pkg::t_result o_result
);
    import wcsg_pkg::*;

    logic [7:0]            r_ram [WAVE_BYTES];
    logic [7:0]            n_ram [WAVE_BYTES];
    logic [7:0]            r_ctrl_dac, n_ctrl_dac;
    logic [7:0]            r_ctrl_vol, n_ctrl_vol;
    logic [7:0]            r_period_lo, n_period_lo;
    logic [7:0]            r_period_hi, n_period_hi;
    logic                  r_dac_on, n_dac_on;
    logic                  r_chan_on, n_chan_on;
    logic [4:0]            r_pos, n_pos;
    logic [12:0]           r_div, n_div;
    logic [3:0]            r_held, n_held;
    logic [WAVE_IDX_W-1:0] r_last_idx, n_last_idx;
    logic [1:0]            r_since_fetch, n_since_fetch;

    logic [3:0]            fetch_nib;
    logic [10:0]           period;
    logic                  wave_hit;
    logic                  ram_ok;
    logic [WAVE_IDX_W-1:0] wave_idx;
    logic [WAVE_IDX_W-1:0] play_idx;
    logic [WAVE_IDX_W-1:0] group_base;

    assign play_idx   = r_pos[4:1];
    assign group_base = {play_idx[WAVE_IDX_W-1:2], 2'b00};
    assign fetch_nib  = r_pos[0] ? r_ram[play_idx][3:0] : r_ram[play_idx][7:4];
    assign period     = {r_period_hi[2:0], r_period_lo};
    assign wave_hit   = (i_item.address[15:4] == WAVE_BASE[15:4]);
    assign ram_ok     = i_colour | (r_since_fetch < FETCH_WINDOW);
    // while playing, wave ram accesses land on the byte last fetched
    assign wave_idx   = r_chan_on ? r_last_idx : i_item.address[WAVE_IDX_W-1:0];

    always_comb begin
        n_ram         = r_ram;
        n_ctrl_dac    = r_ctrl_dac;
        n_ctrl_vol    = r_ctrl_vol;
        n_period_lo   = r_period_lo;
        n_period_hi   = r_period_hi;
        n_dac_on      = r_dac_on;
        n_chan_on     = r_chan_on;
        n_pos         = r_pos;
        n_div         = r_div;
        n_held        = r_held;
        n_last_idx    = r_last_idx;
        n_since_fetch = r_since_fetch;
        o_result      = '0;
        if (i_step) begin
            unique case (i_item.mode)
                MODE_TICK: begin
                    if (r_since_fetch < FETCH_WINDOW) begin
                        n_since_fetch = r_since_fetch + 2'd1;
                    end
                    n_chan_on = r_chan_on & ~i_item.length_expired;
                    if (n_chan_on && r_dac_on && r_ctrl_dac[7]) begin
                        n_div = r_div - 13'd1;
                        if (n_div == '0) begin
                            n_div         = {PERIOD_SPAN - {1'b0, period}, 1'b0};
                            n_held        = wcsg_scale(r_ctrl_vol[6:5], fetch_nib);
                            n_since_fetch = '0;
                            n_last_idx    = play_idx;
                            n_pos         = r_pos + 5'd1;
                        end
                        o_result.sample = n_held;
                    end
                end
                MODE_READ: begin
                    if (wave_hit) begin
                        o_result.read_data = (!r_chan_on || ram_ok) ? r_ram[wave_idx]
                                                                    : READ_OPEN;
                    end else begin
                        unique case (i_item.address)
                            ADDR_NR30: o_result.read_data = r_ctrl_dac | MASK_NR30;
                            ADDR_NR31: o_result.read_data = READ_OPEN;
                            ADDR_NR32: o_result.read_data = r_ctrl_vol | MASK_NR32;
                            ADDR_NR33: o_result.read_data = READ_OPEN;
                            ADDR_NR34: o_result.read_data = r_period_hi | MASK_NR34;
                            default: begin
                                o_result.read_data   = READ_OPEN;
                                o_result.bad_address = 1'b1;
                            end
                        endcase
                    end
                end
                MODE_WRITE: begin
                    if (wave_hit) begin
                        if (!r_chan_on || ram_ok) begin
                            n_ram[wave_idx] = i_item.write_data;
                        end
                    end else begin
                        unique case (i_item.address)
                            ADDR_NR30: begin
                                n_ctrl_dac = i_item.write_data;
                                n_dac_on   = i_item.write_data[7];
                                n_chan_on  = r_chan_on & i_item.write_data[7];
                            end
                            ADDR_NR31: ;
                            ADDR_NR32: n_ctrl_vol  = i_item.write_data;
                            ADDR_NR33: n_period_lo = i_item.write_data;
                            ADDR_NR34: begin
                                // mono retrigger right before a fetch smears wave ram
                                if (!i_colour && i_item.write_data[7] && r_chan_on
                                        && r_div == CORRUPT_DIV) begin
                                    if (play_idx < WAVE_IDX_W'(4)) begin
                                        n_ram[0] = r_ram[play_idx];
                                    end else begin
                                        for (int j = 0; j < 4; j++) begin
                                            n_ram[j] = r_ram[group_base | WAVE_IDX_W'(j)];
                                        end
                                    end
                                end
                                n_period_hi = i_item.write_data;
                                if (i_item.write_data[7]) begin
                                    n_chan_on = r_dac_on;
                                    n_pos     = '0;
                                    n_div     = TRIG_DIVIDER;
                                    // colour model fetches byte 0
                                    if (i_colour) begin
                                        n_since_fetch = '0;
                                        n_last_idx    = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WAVE_BYTES; k++) begin
                r_ram[k] <= wcsg_wave_init(WAVE_IDX_W'(k));
            end
            r_ctrl_dac    <= '0;
            r_ctrl_vol    <= '0;
            r_period_lo   <= '0;
            r_period_hi   <= '0;
            r_dac_on      <= 1'b0;
            r_chan_on     <= 1'b0;
            r_pos         <= '0;
            r_div         <= '0;
            r_held        <= '0;
            r_last_idx    <= '0;
            r_since_fetch <= '0;
        end else begin
            r_ram         <= n_ram;
            r_ctrl_dac    <= n_ctrl_dac;
            r_ctrl_vol    <= n_ctrl_vol;
            r_period_lo   <= n_period_lo;
            r_period_hi   <= n_period_hi;
            r_dac_on      <= n_dac_on;
            r_chan_on     <= n_chan_on;
            r_pos         <= n_pos;
            r_div         <= n_div;
            r_held        <= n_held;
            r_last_idx    <= n_last_idx;
            r_since_fetch <= n_since_fetch;
        end
    end

endmodule

// ----- rtl/wave_channel_sound_generator_unit.sv -----
// top level of the wave channel sound generator: stream ports, apb port, pipeline
// Wave sound channel (channel 3 style). Each input beat is a tick, a bus read or a
// bus write and gives exactly one result beat. An item is taken into an input
// register, processed combinationally against the channel state, and its result
// sits in an output register. One beat per cycle is sustained while m_axis_tready
// is high; each item updates the channel state (wave ram, divider, nibble position)
// as its result is registered. While a result beat waits, the input register can
// still take one beat; after that s_axis_tready stays low until the waiting result
// is taken. colour_mode is written through the apb port at addresses 0 to 3; the
// user must write it only while the block is idle, which the block does not enforce.
module wave_channel_sound_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address[15:0], write_data[23:16], length_expired[24]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample[3:0], read_data[11:4], bad_address[12]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wcsg_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    logic    r_colour;
    t_result res;
    logic    advance;
    logic    step;
    logic    cfg_hit;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == CFG_COLOUR);
    assign prdata  = cfg_hit ? {31'd0, r_colour} : 32'd0;

    wcsg_chan u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_colour (r_colour),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_colour    <= 1'b1;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (psel && penable && pwrite && pready && cfg_hit) begin
                r_colour <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.mode           <= t_mode'(s_axis_tuser);
            r_item.address        <= s_axis_tdata[15:0];
            r_item.write_data     <= s_axis_tdata[23:16];
            r_item.length_expired <= s_axis_tdata[24];
        end
        if (step) begin
            r_out <= res;
        end
    end

endmodule

// ----- rtl/wcsg_chk.sv -----
// port-level checks for the wave channel sound generator, bound to the top level
module wcsg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);

    // a beat that is not taken holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat shown right after reset");

    // foreign address reads back as open bus
    a_bad_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11:4] == 8'hFF
            && m_axis_tdata[3:0] == 4'd0)
        else $error("bad address without open-bus read data");

    // a tick result never carries read data
    a_tick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> m_axis_tdata[12:4] == 9'd0)
        else $error("sample and read data in the same beat");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:13] == 3'd0 && pready)
        else $error("result padding not zero or apb not ready");

endmodule

bind wave_channel_sound_generator_unit wcsg_chk u_wcsg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
